// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the box filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define BF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("box filter assertion failed");

`define BF_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("box filter forbidden condition seen");

`else

`define BF_ASSERT(name, clk, rst_n, prop)

`define BF_ASSERT_NEVER(name, clk, rst_n, prop)

`endif

`endif

// ----- hw/rtl/bf_pkg.sv -----
// ----------------------------------------------------------------------------
// Box filter package
// Types and constants shared by the 3x3 box filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bf_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int IN_ROW_W  = 17;
  localparam int OUT_ROW_W = 16;
  localparam int SUM_W     = 12;
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int RECIP_SH  = 16;

  localparam logic [RECIP_W-1:0]  RECIP_NINE = 13'd7282;
  localparam logic [IN_ROW_W-1:0] IN_ROW_MAX = 17'h1FFFF;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } bf_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/box_filter_3x3_border_copy_unit.sv -----
// ----------------------------------------------------------------------------
// 3x3 box filter with border copy
// Streams grey pixels in raster order and replaces each by its 3x3 mean.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock and delivers one result per clock when
// the output side keeps up. The result for pixel (r,c) is produced by the item
// that carries pixel (r+1,c+1) and is offered on the output after passing the
// line store, window, sum and output registers. Both line stores share one
// memory with one write and one read port; each accepted item reads its column,
// the column is written back when it moves on to the window, and a back-to-back
// access to the same column is forwarded. Pixels on the outer rows and columns
// are copied unchanged, interior pixels get the floor of the neighborhood sum
// divided by nine. After the last pixel of a frame, drain items (tuser high)
// flush the pending width plus one results; m_axis_tlast marks the final one.
// The line stores need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module box_filter_3x3_border_copy_unit import bf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0: pixel_in.
  input  wire logic [PIX_W-1:0]     s_axis_tdata,
  // Fields from bit 0: cmd.
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // Fields from bit 0: pixel_out.
  output logic [PIX_W-1:0]          m_axis_tdata,
  output logic                      m_axis_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             accept;
  logic             push;
  logic [CW-1:0]    addr;
  logic [PIX_W-1:0] push_pixel;
  bf_flags_t        push_flags;
  logic             take;
  logic             col_valid;
  logic [PIX_W-1:0] col_top;
  logic [PIX_W-1:0] col_mid;
  logic [PIX_W-1:0] col_bot;
  bf_flags_t        col_flags;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  bf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .cmd_i       (s_axis_tuser),
    .pixel_i     (s_axis_tdata),
    .push_o      (push),
    .addr_o      (addr),
    .pixel_o     (push_pixel),
    .flags_o     (push_flags)
  );

  bf_line_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_line_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .addr_i      (addr),
    .pixel_i     (push_pixel),
    .flags_i     (push_flags),
    .take_i      (take),
    .ready_o     (s_axis_tready),
    .col_valid_o (col_valid),
    .top_o       (col_top),
    .mid_o       (col_mid),
    .bot_o       (col_bot),
    .flags_o     (col_flags)
  );

  bf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_valid_i (col_valid),
    .top_i       (col_top),
    .mid_i       (col_mid),
    .bot_i       (col_bot),
    .flags_i     (col_flags),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  `BF_ASSERT(empty_output_accepts, clk_i, rst_ni,
    !m_axis_tvalid |-> s_axis_tready)

endmodule

`default_nettype wire

// ----- hw/rtl/bf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Box filter control
// Configuration registers, raster counters and per-item decisions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bf_ctrl import bf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic                 cmd_i,
  input  wire logic [PIX_W-1:0]     pixel_i,
  output logic                      push_o,
  output logic [CW-1:0]             addr_o,
  output logic [PIX_W-1:0]          pixel_o,
  output bf_flags_t                 flags_o
);

  logic [CFG_W_W-1:0]   width_q;
  logic [CFG_H_W-1:0]   height_q;
  logic [CW-1:0]        in_col_q, in_col_d;
  logic [IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]        out_col_q, out_col_d;
  logic [OUT_ROW_W-1:0] out_row_q, out_row_d;

  logic [CW:0]          eff_w;
  logic [CFG_H_W-1:0]   eff_h;
  logic                 done;
  logic                 emit;
  logic                 row_end;
  logic                 col_end;
  logic [CW:0]          in_col_inc;
  logic [CW:0]          out_col_inc;
  logic [OUT_ROW_W:0]   out_row_inc;

  always_comb begin
    if (width_q < 11'd3) begin
      eff_w = (CW+1)'(3);
    end else if ({21'd0, width_q} > 32'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(width_q);
    end
  end

  assign eff_h       = (height_q < 16'd3) ? 16'd3 : height_q;
  assign done        = in_row_q >= {1'b0, eff_h};
  assign in_col_inc  = {1'b0, in_col_q} + (CW+1)'(1);
  assign out_col_inc = {1'b0, out_col_q} + (CW+1)'(1);
  assign out_row_inc = {1'b0, out_row_q} + 17'd1;
  assign row_end     = out_row_inc >= {1'b0, eff_h};
  assign col_end     = out_col_inc >= eff_w;
  assign emit        = (in_row_q >= 17'd2) || ((in_row_q == 17'd1) && (in_col_q != '0));

  assign push_o  = accept_i && !((cmd_i == CMD_DRAIN) && !done);
  assign addr_o  = in_col_q;
  assign pixel_o = done ? '0 : pixel_i;
  assign flags_o = '{emit:   emit,
                     border: (out_row_q == '0) || (out_col_q == '0) || row_end || col_end,
                     last:   row_end && col_end};

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (push_o) begin
      if (in_col_inc >= eff_w) begin
        in_col_d = '0;
        if (in_row_q != IN_ROW_MAX) begin
          in_row_d = in_row_q + 17'd1;
        end
      end else begin
        in_col_d = in_col_inc[CW-1:0];
      end
      if (emit) begin
        if (row_end && col_end) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (col_end) begin
          out_col_d = '0;
          out_row_d = out_row_inc[OUT_ROW_W-1:0];
        end else begin
          out_col_d = out_col_inc[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  `BF_ASSERT(last_clears_counters, clk_i, rst_ni,
    (push_o && emit && row_end && col_end) |=> (in_col_q == '0 && in_row_q == '0))
  `BF_ASSERT(early_drain_ignored, clk_i, rst_ni,
    (accept_i && cmd_i == CMD_DRAIN && !done) |=> ($stable(in_col_q) && $stable(in_row_q)))

endmodule

`default_nettype wire

// ----- hw/rtl/bf_line_mem.sv -----
// ----------------------------------------------------------------------------
// Box filter line store
// Two stacked line stores in one memory, read-modify-write with forwarding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bf_line_mem import bf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [CW-1:0]    addr_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire bf_flags_t        flags_i,
  input  wire logic             take_i,
  output logic                  ready_o,
  output logic                  col_valid_o,
  output logic [PIX_W-1:0]      top_o,
  output logic [PIX_W-1:0]      mid_o,
  output logic [PIX_W-1:0]      bot_o,
  output bf_flags_t             flags_o
);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic               fwd_q;
  logic               v1_q;
  logic [CW-1:0]      addr1_q;
  logic [PIX_W-1:0]   pix1_q;
  bf_flags_t          flags1_q;
  logic [2*PIX_W-1:0] rd_word;
  logic               wr_en;

  assign rd_word     = fwd_q ? fwd_data_q : rdata_q;
  assign wr_en       = v1_q && take_i;
  assign ready_o     = !v1_q || take_i;
  assign col_valid_o = v1_q;
  assign top_o       = rd_word[2*PIX_W-1:PIX_W];
  assign mid_o       = rd_word[PIX_W-1:0];
  assign bot_o       = pix1_q;
  assign flags_o     = flags1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr1_q] <= {mid_o, pix1_q};
    end
    if (push_i) begin
      rdata_q    <= mem[addr_i];
      fwd_data_q <= {mid_o, pix1_q};
      addr1_q    <= addr_i;
      pix1_q     <= pixel_i;
      flags1_q   <= flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (push_i) begin
        v1_q  <= 1'b1;
        fwd_q <= wr_en && (addr_i == addr1_q);
      end else if (take_i) begin
        v1_q <= 1'b0;
      end
    end
  end

  `BF_ASSERT(same_entry_forwarded, clk_i, rst_ni,
    (push_i && wr_en && addr_i == addr1_q) |=> fwd_q)
  `BF_ASSERT_NEVER(push_over_held_column, clk_i, rst_ni,
    push_i && v1_q && !take_i)

endmodule

`default_nettype wire

// ----- hw/rtl/bf_window.sv -----
// ----------------------------------------------------------------------------
// Box filter window
// 3x3 window, neighborhood sum, divide by nine and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bf_window import bf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             col_valid_i,
  input  wire logic [PIX_W-1:0] top_i,
  input  wire logic [PIX_W-1:0] mid_i,
  input  wire logic [PIX_W-1:0] bot_i,
  input  wire bf_flags_t        flags_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [PIX_W-1:0]      out_pixel_o,
  output logic                  out_last_o
);

  logic [PIX_W-1:0]  win_q [3][3];
  logic              v2_q;
  bf_flags_t         flags2_q;
  logic              v3_q;
  logic [SUM_W-1:0]  sum3_q;
  logic [PIX_W-1:0]  ctr3_q;
  logic              border3_q;
  logic              last3_q;
  logic              v4_q;
  logic [PIX_W-1:0]  pix4_q;
  logic              last4_q;
  logic              adv3;
  logic              adv4;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign adv4   = !v4_q || out_ready_i;
  assign adv3   = !v3_q || adv4;
  assign take_o = !v2_q || adv3;

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum = sum + SUM_W'(win_q[r][c]);
      end
    end
  end

  assign prod = PROD_W'(sum3_q) * PROD_W'(RECIP_NINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (col_valid_i && take_o) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_i;
      win_q[1][2] <= mid_i;
      win_q[2][2] <= bot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_valid_i && take_o) begin
      flags2_q <= flags_i;
    end
    if (v2_q && adv3) begin
      sum3_q    <= sum;
      ctr3_q    <= win_q[1][1];
      border3_q <= flags2_q.border;
      last3_q   <= flags2_q.last;
    end
    if (v3_q && adv4) begin
      pix4_q  <= border3_q ? ctr3_q : prod[RECIP_SH +: PIX_W];
      last4_q <= last3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (col_valid_i && take_o) begin
        v2_q <= flags_i.emit;
      end else if (adv3) begin
        v2_q <= 1'b0;
      end
      if (v2_q && adv3) begin
        v3_q <= 1'b1;
      end else if (adv4) begin
        v3_q <= 1'b0;
      end
      if (v3_q && adv4) begin
        v4_q <= 1'b1;
      end else if (out_ready_i) begin
        v4_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = v4_q;
  assign out_pixel_o = pix4_q;
  assign out_last_o  = last4_q;

endmodule

`default_nettype wire
